@@ hdl/assert_macros.svh @@
// Assertion macros used by the top level of the palette matcher.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside of reset.
`define NPCM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition never holds outside of reset.
`define NPCM_NEVER(lbl, cond, msg) \
  `NPCM_ASSERT(lbl, !(cond), msg)

`endif

@@ hdl/npcm_pkg.sv @@
// Shared types and constants of the nearest palette color matcher.
package npcm_pkg;

  // Palette geometry
  localparam int PALETTE_ENTRIES = 256;
  localparam int ADDR_W          = $clog2(PALETTE_ENTRIES);
  localparam int SCAN_MAX        = (PALETTE_ENTRIES < 256) ? PALETTE_ENTRIES : 256;

  // Field widths
  localparam int COLOR_W    = 8;
  localparam int IDX_W      = 8;
  localparam int ENTRY_W    = 3 * COLOR_W;
  localparam int CNT_W      = 9;
  localparam int SQ_W       = 2 * COLOR_W;
  localparam int SQ_SUM_W   = SQ_W + 2;
  localparam int DIST_W     = 23;

  // Constants
  localparam logic [CNT_W-1:0]  SEARCH_RESET = CNT_W'(248);
  localparam logic [CNT_W-1:0]  SCAN_LIMIT   = CNT_W'(SCAN_MAX);
  localparam logic [DIST_W-1:0] NO_MATCH     = DIST_W'(23'h7F_FFFF);
  localparam logic [DIST_W-1:0] MAX_DIST     = DIST_W'(3 * 255 * 255);

  // Item commands
  typedef enum logic [0:0] {
    CMD_WRITE = 1'b0,
    CMD_QUERY = 1'b1
  } npcm_cmd_e;

  // Scored palette entry handed from the distance stage to the search
  typedef struct packed {
    logic              vld;
    logic [IDX_W-1:0]  idx;
    logic [DIST_W-1:0] dist_sq;
  } npcm_cand_t;

endpackage

@@ hdl/npcm_dist.sv @@
// Squared RGB distance stage: one palette entry scored per cycle.
module npcm_dist (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    vld_i,
  input  logic [npcm_pkg::IDX_W-1:0]              idx_i,
  input  logic [npcm_pkg::ENTRY_W-1:0]            entry_i,
  input  logic [npcm_pkg::COLOR_W-1:0]            red_i,
  input  logic [npcm_pkg::COLOR_W-1:0]            green_i,
  input  logic [npcm_pkg::COLOR_W-1:0]            blue_i,
  output npcm_pkg::npcm_cand_t                    cand_o
);
  import npcm_pkg::*;

  logic [COLOR_W-1:0]  ent_r, ent_g, ent_b;
  logic [COLOR_W-1:0]  dif_r, dif_g, dif_b;
  logic                vld_q;
  logic [IDX_W-1:0]    idx_q;
  logic [SQ_W-1:0]     sq_r_q, sq_g_q, sq_b_q;
  logic [SQ_SUM_W-1:0] sum;

  // Split the stored word and take absolute differences
  assign ent_r = entry_i[3*COLOR_W-1:2*COLOR_W];
  assign ent_g = entry_i[2*COLOR_W-1:COLOR_W];
  assign ent_b = entry_i[COLOR_W-1:0];

  assign dif_r = (ent_r > red_i)   ? ent_r - red_i   : red_i - ent_r;
  assign dif_g = (ent_g > green_i) ? ent_g - green_i : green_i - ent_g;
  assign dif_b = (ent_b > blue_i)  ? ent_b - blue_i  : blue_i - ent_b;

  // Register the squares with their entry index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q  <= idx_i;
    sq_r_q <= dif_r * dif_r;
    sq_g_q <= dif_g * dif_g;
    sq_b_q <= dif_b * dif_b;
  end

  // Sum the squares for the compare in the search stage
  assign sum = SQ_SUM_W'(sq_r_q) + SQ_SUM_W'(sq_g_q) + SQ_SUM_W'(sq_b_q);

  assign cand_o.vld     = vld_q;
  assign cand_o.idx     = idx_q;
  assign cand_o.dist_sq = DIST_W'(sum);

endmodule

@@ hdl/nearest_palette_color_match.sv @@
// Top level of the nearest palette color matcher.
//
// Holds a 256-entry RGB palette in a single-port-write, synchronous-read
// memory. A write item stores one entry; it gives no result. A query item
// scans entries 0 .. N-1, where N is searched_entries clipped to the palette
// size, reading one entry per cycle from the palette memory, and returns the
// lowest index with the smallest squared RGB distance plus that distance (the
// fallback index and 0x7FFFFF when N is zero). A query with N nonzero stalls
// the input while it issues one memory read per entry, drains the read,
// square and compare stages and loads the result; an empty search stalls it
// while the result loads. Either stretches while an earlier result still
// waits in the output register. That register lets the next item be
// accepted while a result waits. The palette has no reset; entries must be
// written before they are searched.
module nearest_palette_color_match (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Configuration
  input  logic                         cfg_we_i,
  input  logic [npcm_pkg::CNT_W-1:0]   cfg_wdata_i,
  // Input items
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         command_i,
  input  logic [npcm_pkg::IDX_W-1:0]   entry_index_i,
  input  logic [npcm_pkg::COLOR_W-1:0] red_i,
  input  logic [npcm_pkg::COLOR_W-1:0] green_i,
  input  logic [npcm_pkg::COLOR_W-1:0] blue_i,
  // Result items
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [npcm_pkg::IDX_W-1:0]   match_index_o,
  output logic [npcm_pkg::DIST_W-1:0]  match_distance_o
);
  import npcm_pkg::*;

  `include "assert_macros.svh"

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_e;

  state_e             state_q;
  logic [CNT_W-1:0]   searched_q;
  logic [CNT_W-1:0]   limit_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [COLOR_W-1:0] qr_q, qg_q, qb_q;
  logic [IDX_W-1:0]   best_idx_q;
  logic [DIST_W-1:0]  best_dist_q;
  logic               out_valid_q;
  logic [IDX_W-1:0]   out_idx_q;
  logic [DIST_W-1:0]  out_dist_q;

  logic [ENTRY_W-1:0] palette_q [PALETTE_ENTRIES];
  logic [ENTRY_W-1:0] rd_data_q;
  logic               rd_vld_q;
  logic [IDX_W-1:0]   rd_idx_q;

  logic               in_acc;
  logic               is_query;
  logic               wr_in_range;
  logic               mem_we;
  logic               rd_en;
  logic [ADDR_W-1:0]  rd_addr;
  logic [CNT_W-1:0]   lim_eff;
  logic               scan_done;
  logic               out_free;
  npcm_cand_t         cand;

  // Decode the input handshake
  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign is_query    = (npcm_cmd_e'(command_i) == CMD_QUERY);
  assign wr_in_range = (32'(entry_index_i) < PALETTE_ENTRIES);
  assign mem_we      = in_acc && !is_query && wr_in_range;

  // Clip the search length to what the palette and the index can hold
  assign lim_eff = (searched_q > SCAN_LIMIT) ? SCAN_LIMIT : searched_q;

  // Issue one palette read per cycle while the scan runs
  assign rd_en   = (state_q == ST_SCAN) && (cnt_q < limit_q);
  assign rd_addr = ADDR_W'(cnt_q);

  // Scan ends once all reads are issued and the pipeline is empty
  assign scan_done = !rd_en && !rd_vld_q && !cand.vld;
  assign out_free  = !out_valid_q || !out_stall_i;

  // Palette memory: writes only in idle, reads only while scanning
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      palette_q[ADDR_W'(entry_index_i)] <= {red_i, green_i, blue_i};
    end
    if (rd_en) begin
      rd_data_q <= palette_q[rd_addr];
    end
  end

  // Track the read in flight
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
      rd_idx_q <= '0;
    end else begin
      rd_vld_q <= rd_en;
      rd_idx_q <= cnt_q[IDX_W-1:0];
    end
  end

  // Score the entry just read
  npcm_dist u_dist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .vld_i   (rd_vld_q),
    .idx_i   (rd_idx_q),
    .entry_i (rd_data_q),
    .red_i   (qr_q),
    .green_i (qg_q),
    .blue_i  (qb_q),
    .cand_o  (cand)
  );

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      searched_q <= SEARCH_RESET;
    end else if (cfg_we_i) begin
      searched_q <= cfg_wdata_i;
    end
  end

  // Control: accept, scan, keep the best entry, hand off the result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      limit_q     <= '0;
      cnt_q       <= '0;
      qr_q        <= '0;
      qg_q        <= '0;
      qb_q        <= '0;
      best_idx_q  <= '0;
      best_dist_q <= NO_MATCH;
      out_valid_q <= 1'b0;
      out_idx_q   <= '0;
      out_dist_q  <= '0;
    end else begin
      // Drop the result once taken, unless a new one loads now
      if (out_valid_q && !out_stall_i && (state_q != ST_FINISH)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc && is_query) begin
            qr_q        <= red_i;
            qg_q        <= green_i;
            qb_q        <= blue_i;
            best_idx_q  <= entry_index_i;
            best_dist_q <= NO_MATCH;
            limit_q     <= lim_eff;
            cnt_q       <= '0;
            state_q     <= (lim_eff == '0) ? ST_FINISH : ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (rd_en) begin
            cnt_q <= cnt_q + 1'b1;
          end
          if (cand.vld && (cand.dist_sq < best_dist_q)) begin
            best_dist_q <= cand.dist_sq;
            best_idx_q  <= cand.idx;
          end
          if (scan_done) begin
            state_q <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_idx_q   <= best_idx_q;
            out_dist_q  <= best_dist_q;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o      = out_valid_q;
  assign match_index_o    = out_idx_q;
  assign match_distance_o = out_dist_q;

  // Scored distances stay within three full-scale squares
  `NPCM_ASSERT(a_cand_range, cand.vld |-> (cand.dist_sq <= MAX_DIST), "distance out of range")
  // The read counter never runs past the search length
  `NPCM_ASSERT(a_cnt_bound, (state_q == ST_SCAN) |-> (cnt_q <= limit_q), "scan counter overran")
  // The pipeline is drained before a new item is taken
  `NPCM_NEVER(a_idle_drained, (state_q == ST_IDLE) && (cand.vld || rd_vld_q), "busy in idle")
  // A non-empty search always finds an entry
  `NPCM_ASSERT(a_found, (state_q == ST_FINISH && limit_q != '0) |-> best_dist_q <= MAX_DIST, "no entry")

endmodule
